// File: hw/rtl/oale_pkg.sv
// Shared types and constants for the ordered array list engine.
// No dependencies; compiled first.
`default_nettype none

package oale_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int FUNC_W   = 3;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 9;
   localparam int STATUS_W = 3;
   localparam int FIDX_W   = 8;
   localparam int OCNT_W   = 9;

   // request codes
   localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
   localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
   localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd5;
   localparam logic [FUNC_W-1:0] FN_FIND      = 3'd6;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   // first-match tree geometry
   localparam int GRP    = 16;
   localparam int GRP_W  = $clog2(GRP);
   localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
   localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

   // broadcast from control to every cell
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [IDX_W-1:0]  pos;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] key;
      logic [CNT_W-1:0]  count;
   } cell_bus_type;

endpackage

`default_nettype wire

// File: hw/rtl/oale_req_if.sv
// Request channel interface: valid/ready plus request payload.
// Depends on oale_pkg.
`default_nettype none

interface oale_req_if
   import oale_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DATA_W-1:0] value;
   logic [POS_W-1:0]  position;

   modport source (output valid, output func, output value, output position, input ready);
   modport sink   (input valid, input func, input value, input position, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/oale_rsp_if.sv
// Response channel interface: valid/ready plus response payload.
// Depends on oale_pkg.
`default_nettype none

interface oale_rsp_if
   import oale_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FIDX_W-1:0]   found_index;
   logic [OCNT_W-1:0]   count;

   modport source (output valid, output status, output found_index, output count, input ready);
   modport sink   (input valid, input status, input found_index, input count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/oale_cell.sv
// One storage cell of the list: holds an entry, shifts with its neighbors,
// and flags a key match. Depends on oale_pkg.
`default_nettype none

module oale_cell
   import oale_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [IDX_W-1:0]  cell_index,
   input  wire cell_bus_type      bus,
   input  wire logic [DATA_W-1:0] left_entry,
   input  wire logic [DATA_W-1:0] right_entry,
   output logic      [DATA_W-1:0] entry,
   output logic                   match
);

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      if (bus.ins) begin
         if (cell_index > bus.pos) begin
            entry_in = left_entry;
         end else if (cell_index == bus.pos) begin
            entry_in = bus.value;
         end
      end else if (bus.del) begin
         if (cell_index >= bus.pos) begin
            entry_in = right_entry;
         end
      end
      match_in = (entry_ff == bus.key) && (32'(cell_index) < 32'(bus.count));
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// File: hw/rtl/oale_first_match.sv
// Two-level registered priority encoder: lowest set match bit.
// Depends on oale_pkg.
`default_nettype none

module oale_first_match
   import oale_pkg::*;
(
   input  wire logic                clock,
   input  wire logic [CAPACITY-1:0] match,
   output logic                     hit,
   output logic      [IDX_W-1:0]    index
);

   logic [NGRP*GRP-1:0] padded;
   logic [NGRP-1:0]     grp_hit_ff, grp_hit_in;
   logic [GRP_W-1:0]    grp_sub_ff [NGRP];
   logic [GRP_W-1:0]    grp_sub_in [NGRP];
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    index_ff, index_in;

   assign padded = (NGRP*GRP)'(match);

   // level 1: first bit inside each group
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_hit_in[g] = |padded[g*GRP +: GRP];
         grp_sub_in[g] = '0;
         for (int b = GRP - 1; b >= 0; b--) begin
            if (padded[g*GRP + b]) grp_sub_in[g] = GRP_W'(b);
         end
      end
   end

   // level 2: first group with a hit
   always_comb begin
      logic [NGRP_W-1:0] grp_sel;
      grp_sel = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) grp_sel = NGRP_W'(g);
      end
      hit_in   = |grp_hit_ff;
      index_in = IDX_W'((32'(grp_sel) << GRP_W) | 32'(grp_sub_ff[grp_sel]));
   end

   always_ff @(posedge clock) begin
      grp_hit_ff <= grp_hit_in;
      grp_sub_ff <= grp_sub_in;
      hit_ff     <= hit_in;
      index_ff   <= index_in;
   end

   assign hit   = hit_ff;
   assign index = index_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ordered_array_list_engine.sv
// Ordered array list engine: a row of storage cells holding a list of
// signed 32-bit values, with insert, delete and find operations.
//
// Channels: req_chan (sink) carries func, value and position; rsp_chan
// (source) carries status, found_index and the list count afterwards.
// A transaction completes on a rising clock edge with valid and ready high.
//
// Timing:
//   insert, delete, unused code: result registered at acceptance;
//     one such transaction per cycle while the receiver keeps up.
//   find: key register, cell compare register, group encoder register,
//     final encoder register, response register; the next request can be
//     taken in the cycle after the response is loaded.
// The cells shift all entries in parallel, so list edits take equally long
// regardless of position; find cost is set by the two-level encoder tree.
//
// Reset (synchronous, active high) empties the list and drops any pending
// response; entry storage itself is not cleared. If the receiver stalls,
// the response register holds and no new request is taken until it drains.
// Depends on oale_pkg, oale_req_if, oale_rsp_if, oale_cell, oale_first_match.
`default_nettype none

module ordered_array_list_engine
   import oale_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   oale_req_if.sink   req_chan,
   oale_rsp_if.source rsp_chan
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CMP  = 5'b00010,
      S_GRP  = 5'b00100,
      S_SEL  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DATA_W-1:0]   key_ff, key_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FIDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [OCNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                out_free;
   logic                accept;
   cell_bus_type        bus;

   logic [DATA_W-1:0]   cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_match;
   logic                find_hit;
   logic [IDX_W-1:0]    find_index;

   // status and edit decode for the current request
   logic [STATUS_W-1:0] op_status;
   logic                op_ins, op_del, op_find;
   logic [31:0]         op_pos;
   logic [31:0]         count_w;

   assign out_free        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready  = (state_ff == S_IDLE) && out_free;
   assign accept          = req_chan.valid && req_chan.ready;

   always_comb begin
      count_w   = 32'(count_ff);
      op_status = ST_OK;
      op_ins    = 1'b0;
      op_del    = 1'b0;
      op_find   = 1'b0;
      op_pos    = 32'(req_chan.position);
      unique case (req_chan.func)
         FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
            if (req_chan.func == FN_INS_FRONT) op_pos = '0;
            else if (req_chan.func == FN_INS_BACK) op_pos = count_w;
            // fullness wins over a bad position
            if (count_w >= 32'(CAPACITY)) op_status = ST_FULL;
            else if (op_pos > count_w) op_status = ST_BADPOS;
            else op_ins = 1'b1;
         end
         FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS: begin
            if (req_chan.func == FN_DEL_FRONT) op_pos = '0;
            else if (req_chan.func == FN_DEL_BACK) op_pos = count_w - 32'd1;
            // emptiness wins over a bad position
            if (count_w == '0) op_status = ST_EMPTY;
            else if (op_pos >= count_w) op_status = ST_BADPOS;
            else op_del = 1'b1;
         end
         FN_FIND: begin
            op_find = 1'b1;
         end
         default: begin
            op_status = ST_OK;   // unused code: no operation
         end
      endcase
   end

   // cell broadcast; edits land at the acceptance edge
   always_comb begin
      bus.ins   = accept && op_ins;
      bus.del   = accept && op_del;
      bus.pos   = IDX_W'(op_pos);
      bus.value = req_chan.value;
      bus.key   = key_ff;
      bus.count = count_ff;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (op_find) begin
                  key_in   = req_chan.value;
                  state_in = S_CMP;
               end else begin
                  if (op_ins) count_in = count_ff + CNT_W'(1);
                  else if (op_del) count_in = count_ff - CNT_W'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = op_status;
                  rsp_index_in  = '0;
                  rsp_count_in  = OCNT_W'(op_ins ? count_w + 32'd1 :
                                          op_del ? count_w - 32'd1 : count_w);
               end
            end
         end
         S_CMP: state_in = S_GRP;
         S_GRP: state_in = S_SEL;
         S_SEL: state_in = S_OUT;
         S_OUT: begin
            // encoder outputs hold steady until the next request
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = find_hit ? ST_OK : ST_NOTFOUND;
               rsp_index_in  = find_hit ? FIDX_W'(32'(find_index)) : '0;
               rsp_count_in  = OCNT_W'(count_w);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // row of cells; each takes from its left on insert, its right on delete
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_entry;
      logic [DATA_W-1:0] right_entry;
      if (i == 0) begin : g_first
         assign left_entry = req_chan.value;
      end else begin : g_mid
         assign left_entry = cell_entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end
      oale_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .bus         (bus),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .match       (cell_match[i])
      );
   end

   oale_first_match u_first_match (
      .clock (clock),
      .match (cell_match),
      .hit   (find_hit),
      .index (find_index)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_index = rsp_index_ff;
   assign rsp_chan.count       = rsp_count_ff;

endmodule

`default_nettype wire
